[hdl/assert_macros.svh]
// Assertion helpers for the RTL, included by brusselator_rk4_step.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/brs_pkg.sv]
package brs_pkg;

	// Field widths.
	localparam int QW   = 32;   // Q16.16 state and result width
	localparam int CW   = 31;   // coefficient register width
	localparam int DW   = 17;   // step size register width
	localparam int IW   = 2;    // configuration index width
	localparam int SW   = 35;   // width of k1 + 2*k2 + 2*k3 + k4

	// Digit-serial multiplier: 36-bit signed operands, 4-bit digits.
	localparam int MW   = 36;
	localparam int PW   = 2 * MW;
	localparam int DIGW = 4;
	localparam int NDIG = MW / DIGW;
	localparam int CNTW = $clog2(NDIG);

	// Bit-serial division by three of an offset, nonnegative dividend.
	localparam int DIVW  = 40;
	localparam int DCNTW = $clog2(DIVW);
	localparam int DOFSB = 37;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_WB,
		ST_COMB,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_AX,
		OP_TX,
		OP_TY,
		OP_BX,
		OP_INCX,
		OP_INCY,
		OP_FINX,
		OP_FINY
	} op_t;

	typedef enum logic [IW-1:0] {
		REG_COEF_A,
		REG_COEF_B,
		REG_STEP_SIZE
	} reg_idx_t;

	localparam logic ACT_STEP = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	typedef struct packed {
		logic                 ov;
		logic signed [QW-1:0] val;
	} sat_t;

	// Clamp a wide signed value to 32 bits and flag the clamp.
	function automatic sat_t sat32(input logic signed [PW-1:0] v);
		sat_t r;
		r.ov = !((&v[PW-1:QW-1]) || (~|v[PW-1:QW-1]));
		if (r.ov) begin
			r.val = v[PW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
		end else begin
			r.val = v[QW-1:0];
		end
		return r;
	endfunction

endpackage

[hdl/brs_ifs.sv]
interface brs_req_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic signed [brs_pkg::QW-1:0] load_x;
	logic signed [brs_pkg::QW-1:0] load_y;
	modport source (output valid, action, load_x, load_y, input ready);
	modport sink   (input valid, action, load_x, load_y, output ready);
endinterface

interface brs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic signed [brs_pkg::QW-1:0] new_x;
	logic signed [brs_pkg::QW-1:0] new_y;
	logic                          overflow;
	modport source (output valid, new_x, new_y, overflow, input ready);
	modport sink   (input valid, new_x, new_y, overflow, output ready);
endinterface

interface brs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [brs_pkg::IW-1:0]        index;
	logic [brs_pkg::QW-1:0]        data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hdl/brusselator_rk4_step.sv]
// Brusselator integrator: holds concentrations x and y in signed Q16.16.
// Channel req carries one item: action 0 advances x and y by one classic
// fourth-order Runge-Kutta step of size dt, action 1 loads load_x and load_y.
// Channel rsp returns one item per request: new x, new y and an overflow
// flag that is set when any intermediate value or result was clamped.
// Channel cfg writes coef_a (index 0), coef_b (index 1) and step_size
// (index 2); it is always ready and should only be used while idle.
// A load item goes to x and y when accepted and, in ST_DONE, on to the output register once that register is free.
// A step item runs 24 products through one digit-serial multiplier (4-bit
// digits, each product with operand load and write-back), four derivative
// combine steps, two divisions by three (40 quotient bits and a final add)
// for the dt/6 scaling, and a hand-over to the output register.
// Only one item is processed at a time; the next item can be accepted in the
// cycle after the result has moved to the output register. A stalled result
// holds in the output register and only blocks the block when the next
// result is done.
// Reset (arst_n low) clears x and y to zero, restores coef_a = 1.0,
// coef_b = 10.0 and dt = 655/65536, and empties the output register.
module brusselator_rk4_step (
	input logic         clk,
	input logic         arst_n,
	brs_req_if.sink     req,
	brs_rsp_if.source   rsp,
	brs_cfg_if.sink     cfg
);

	localparam int QW = brs_pkg::QW;
	localparam int PW = brs_pkg::PW;
	localparam int MW = brs_pkg::MW;
	localparam int SW = brs_pkg::SW;
	localparam int DIVW = brs_pkg::DIVW;
	localparam int DIGW = brs_pkg::DIGW;
	localparam logic [DIVW-1:0] DIV_OFS = DIVW'(3) << brs_pkg::DOFSB;
	localparam logic signed [DIVW:0] DIV_BIAS = (DIVW+1)'(1) << brs_pkg::DOFSB;

	brs_pkg::state_t state_q, state_d;
	brs_pkg::op_t    op_q;
	logic [1:0]      stage_q;

	// Configuration registers.
	logic [brs_pkg::CW-1:0] coef_a_q, coef_b_q;
	logic [brs_pkg::DW-1:0] dt_q;

	// Integrator state and per-step working values.
	logic signed [QW-1:0] x0_q, y0_q, xs_q, ys_q, t_q, bx_q, kx_q, ky_q;
	logic signed [SW-1:0] sumx_q, sumy_q;
	logic                 ovf_q;

	// Multiplier: multiplicand shifts left one digit per cycle, multiplier
	// shifts right, and the partial products accumulate in acc_q.
	logic signed [PW-1:0]        a_q, acc_q;
	logic [MW-1:0]               b_q;
	logic [brs_pkg::CNTW-1:0]    cnt_q;
	logic signed [DIGW:0]        digit;
	logic signed [PW-1:0]        term;
	logic signed [PW-1:0]        opa;
	logic [MW-1:0]               opb;

	// Division by three, one quotient bit per cycle.
	logic [DIVW-1:0]             div_n_q;
	logic [1:0]                  div_r_q;
	logic [brs_pkg::DCNTW-1:0]   div_cnt_q;
	logic [2:0]                  div_r3;
	logic                        div_ge;

	// Output register.
	logic                 out_valid_q, out_ov_q;
	logic signed [QW-1:0] out_x_q, out_y_q;

	// Write-back values.
	logic signed [PW-1:0] r16, r17, rinc, rfin, half, kxw, kyw, finv;
	logic signed [DIVW:0] divres;
	brs_pkg::sat_t        s_prod, s_inc, s_kx, s_ky, s_fin;
	logic signed [QW-1:0] base;

	logic req_acc, out_free, last_dig, last_div;

	// ---------------------------------------------------------------------
	// Handshake outputs.
	always_comb begin
		req.ready    = (state_q == brs_pkg::ST_IDLE);
		cfg.ready    = 1'b1;
		rsp.valid    = out_valid_q;
		rsp.new_x    = out_x_q;
		rsp.new_y    = out_y_q;
		rsp.overflow = out_ov_q;
	end

	assign req_acc  = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign last_dig = (cnt_q == brs_pkg::CNTW'(brs_pkg::NDIG - 1));
	assign last_div = (div_cnt_q == brs_pkg::DCNTW'(DIVW - 1));

	// ---------------------------------------------------------------------
	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			brs_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_d = (req.action == brs_pkg::ACT_LOAD) ? brs_pkg::ST_DONE
						: brs_pkg::ST_LOAD;
				end
			end
			brs_pkg::ST_LOAD: state_d = brs_pkg::ST_MUL;
			brs_pkg::ST_MUL: begin
				if (last_dig) begin
					state_d = brs_pkg::ST_WB;
				end
			end
			brs_pkg::ST_WB: begin
				case (op_q)
					brs_pkg::OP_BX:   state_d = brs_pkg::ST_COMB;
					brs_pkg::OP_FINX,
					brs_pkg::OP_FINY: state_d = brs_pkg::ST_DIV;
					default:          state_d = brs_pkg::ST_LOAD;
				endcase
			end
			brs_pkg::ST_COMB: state_d = brs_pkg::ST_LOAD;
			brs_pkg::ST_DIV: begin
				if (last_div) begin
					state_d = brs_pkg::ST_FIN;
				end
			end
			brs_pkg::ST_FIN: begin
				state_d = (op_q == brs_pkg::OP_FINX) ? brs_pkg::ST_LOAD
					: brs_pkg::ST_DONE;
			end
			brs_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = brs_pkg::ST_IDLE;
				end
			end
			default: state_d = brs_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Operand selection and multiplier digit.
	always_comb begin
		opa = '0;
		opb = '0;
		case (op_q)
			brs_pkg::OP_AX: begin
				opa = PW'(coef_a_q);
				opb = MW'(xs_q);
			end
			brs_pkg::OP_TX: begin
				opa = PW'(t_q);
				opb = MW'(xs_q);
			end
			brs_pkg::OP_TY: begin
				opa = PW'(t_q);
				opb = MW'(ys_q);
			end
			brs_pkg::OP_BX: begin
				opa = PW'(coef_b_q);
				opb = MW'(xs_q);
			end
			brs_pkg::OP_INCX: begin
				opa = PW'(kx_q);
				opb = MW'(dt_q);
			end
			brs_pkg::OP_INCY: begin
				opa = PW'(ky_q);
				opb = MW'(dt_q);
			end
			brs_pkg::OP_FINX: begin
				opa = PW'(sumx_q);
				opb = MW'(dt_q);
			end
			brs_pkg::OP_FINY: begin
				opa = PW'(sumy_q);
				opb = MW'(dt_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		// The top digit carries the sign of the multiplier.
		digit = {last_dig & b_q[DIGW-1], b_q[DIGW-1:0]};
		term  = a_q * digit;
	end

	// ---------------------------------------------------------------------
	// Rounding, saturation and derivative arithmetic.
	always_comb begin
		r16    = (acc_q + (PW'(1) <<< 15)) >>> 16;
		r17    = (acc_q + (PW'(1) <<< 16)) >>> 17;
		// Half steps for k1 and k2, a full step for k3.
		rinc   = (stage_q == 2'd2) ? r16 : r17;
		base   = (op_q == brs_pkg::OP_INCY || op_q == brs_pkg::OP_FINY) ? y0_q : x0_q;
		s_prod = brs_pkg::sat32(r16);
		s_inc  = brs_pkg::sat32(PW'(base) + rinc);
		// dt*sum/(6*65536), rounded to nearest: add 3*2^16, shift right by 16, then
		// floor-halve, then floor-divide by three.
		rfin   = (acc_q + PW'(196608)) >>> 16;
		half   = rfin >>> 1;
		kxw    = PW'(32'sh0001_0000) - (PW'(bx_q) + PW'(xs_q)) + PW'(t_q);
		kyw    = PW'(bx_q) - PW'(t_q);
		s_kx   = brs_pkg::sat32(kxw);
		s_ky   = brs_pkg::sat32(kyw);
		divres = $signed({1'b0, div_n_q}) - DIV_BIAS;
		finv   = PW'(base) + PW'(divres);
		s_fin  = brs_pkg::sat32(finv);
		div_r3 = {div_r_q, div_n_q[DIVW-1]};
		div_ge = (div_r3 >= 3'd3);
	end

	// ---------------------------------------------------------------------
	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brs_pkg::ST_IDLE;
			op_q        <= brs_pkg::OP_AX;
			stage_q     <= '0;
			cnt_q       <= '0;
			div_cnt_q   <= '0;
			coef_a_q    <= brs_pkg::CW'(65536);
			coef_b_q    <= brs_pkg::CW'(655360);
			dt_q        <= brs_pkg::DW'(655);
			x0_q        <= '0;
			y0_q        <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg.valid && cfg.ready) begin
				case (brs_pkg::reg_idx_t'(cfg.index))
					brs_pkg::REG_COEF_A:    coef_a_q <= cfg.data[brs_pkg::CW-1:0];
					brs_pkg::REG_COEF_B:    coef_b_q <= cfg.data[brs_pkg::CW-1:0];
					brs_pkg::REG_STEP_SIZE: dt_q     <= cfg.data[brs_pkg::DW-1:0];
					default: ;
				endcase
			end

			// A new result fills the output register; otherwise a taken one empties it.
			if (state_q == brs_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				brs_pkg::ST_IDLE: begin
					if (req_acc) begin
						ovf_q   <= 1'b0;
						op_q    <= brs_pkg::OP_AX;
						stage_q <= '0;
						if (req.action == brs_pkg::ACT_LOAD) begin
							x0_q <= req.load_x;
							y0_q <= req.load_y;
						end
					end
				end
				brs_pkg::ST_LOAD: cnt_q <= '0;
				brs_pkg::ST_MUL:  cnt_q <= cnt_q + 1'b1;
				brs_pkg::ST_WB: begin
					div_cnt_q <= '0;
					case (op_q)
						brs_pkg::OP_AX: begin
							op_q  <= brs_pkg::OP_TX;
							ovf_q <= ovf_q | s_prod.ov;
						end
						brs_pkg::OP_TX: begin
							op_q  <= brs_pkg::OP_TY;
							ovf_q <= ovf_q | s_prod.ov;
						end
						brs_pkg::OP_TY: begin
							op_q  <= brs_pkg::OP_BX;
							ovf_q <= ovf_q | s_prod.ov;
						end
						brs_pkg::OP_BX:   ovf_q <= ovf_q | s_prod.ov;
						brs_pkg::OP_INCX: begin
							op_q  <= brs_pkg::OP_INCY;
							ovf_q <= ovf_q | s_inc.ov;
						end
						brs_pkg::OP_INCY: begin
							op_q    <= brs_pkg::OP_AX;
							stage_q <= stage_q + 1'b1;
							ovf_q   <= ovf_q | s_inc.ov;
						end
						default: ;
					endcase
				end
				brs_pkg::ST_COMB: begin
					ovf_q <= ovf_q | s_kx.ov | s_ky.ov;
					op_q  <= (stage_q == 2'd3) ? brs_pkg::OP_FINX : brs_pkg::OP_INCX;
				end
				brs_pkg::ST_DIV: div_cnt_q <= div_cnt_q + 1'b1;
				brs_pkg::ST_FIN: begin
					ovf_q <= ovf_q | s_fin.ov;
					if (op_q == brs_pkg::OP_FINX) begin
						x0_q <= s_fin.val;
						op_q <= brs_pkg::OP_FINY;
					end else begin
						y0_q <= s_fin.val;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			brs_pkg::ST_IDLE: begin
				xs_q   <= x0_q;
				ys_q   <= y0_q;
				sumx_q <= '0;
				sumy_q <= '0;
			end
			brs_pkg::ST_LOAD: begin
				a_q   <= opa;
				b_q   <= opb;
				acc_q <= '0;
			end
			brs_pkg::ST_MUL: begin
				acc_q <= acc_q + term;
				a_q   <= a_q <<< DIGW;
				b_q   <= b_q >> DIGW;
			end
			brs_pkg::ST_WB: begin
				div_r_q <= '0;
				div_n_q <= DIVW'(half) + DIV_OFS;
				case (op_q)
					brs_pkg::OP_AX,
					brs_pkg::OP_TX,
					brs_pkg::OP_TY:   t_q  <= s_prod.val;
					brs_pkg::OP_BX:   bx_q <= s_prod.val;
					brs_pkg::OP_INCX: xs_q <= s_inc.val;
					brs_pkg::OP_INCY: ys_q <= s_inc.val;
					default: ;
				endcase
			end
			brs_pkg::ST_COMB: begin
				kx_q <= s_kx.val;
				ky_q <= s_ky.val;
				if (stage_q == 2'd1 || stage_q == 2'd2) begin
					sumx_q <= sumx_q + (SW'(s_kx.val) <<< 1);
					sumy_q <= sumy_q + (SW'(s_ky.val) <<< 1);
				end else begin
					sumx_q <= sumx_q + SW'(s_kx.val);
					sumy_q <= sumy_q + SW'(s_ky.val);
				end
			end
			brs_pkg::ST_DIV: begin
				div_r_q <= div_ge ? 2'(div_r3 - 3'd3) : div_r3[1:0];
				div_n_q <= {div_n_q[DIVW-2:0], div_ge};
			end
			brs_pkg::ST_DONE: begin
				if (out_free) begin
					out_x_q  <= x0_q;
					out_y_q  <= y0_q;
					out_ov_q <= ovf_q;
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------------
	// Assertions.
	`include "assert_macros.svh"

	`ASSERT_NEXT(a_mul_ends, state_q == brs_pkg::ST_MUL && last_dig, state_q == brs_pkg::ST_WB, "mul")
	`ASSERT_IMPL(a_div_final, state_q == brs_pkg::ST_DIV, stage_q == 2'd3, "early division")
	`ASSERT_NEXT(a_load_done, req_acc && req.action, state_q == brs_pkg::ST_DONE, "load")

endmodule

[sim/brs_tb_ifs.sv]
`timescale 1ns / 100ps

// The testbench uses the interfaces of the RTL itself (brs_req_if, brs_rsp_if, brs_cfg_if).
// This file only holds the item types that the driver queue and the expected-result queue carry.
package brs_tb_pkg;

	typedef struct {
		logic                          action;
		logic signed [brs_pkg::QW-1:0] load_x;
		logic signed [brs_pkg::QW-1:0] load_y;
	} conc_cmd_t;

	typedef struct {
		logic signed [brs_pkg::QW-1:0] new_x;
		logic signed [brs_pkg::QW-1:0] new_y;
		logic                          overflow;
	} conc_result_t;
endpackage

[sim/brusselator_rk4_step_test.sv]
`timescale 1ns / 100ps

module brusselator_rk4_step_test;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	brs_req_if req ();
	brs_rsp_if rsp ();
	brs_cfg_if cfg ();

	brusselator_rk4_step u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	always #5 clk = ~clk;

	// The model of the block: its own copy of the concentrations and the registers.
	longint mdl_x, mdl_y, mdl_a, mdl_b, mdl_dt;
	bit     mdl_ovf;

	brs_tb_pkg::conc_cmd_t    pending_cmds[$];
	brs_tb_pkg::conc_result_t expected_results[$];
	int  n_fail = 0;
	int  n_results = 0;
	int  n_steps = 0;
	int  n_loads = 0;
	int  n_sat = 0;
	bit  stim_done = 0;
	bit  req_taken = 0;
	int  idle_cycles = 0;
	// The slowest item is a step; even with the receiver's stalls and the sender's gaps, a
	// correct run never goes as long as this limit with no item accepted.
	localparam int WATCHDOG_LIMIT = 5000;

	// Clamp to the 32-bit range and note the clamp.
	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			mdl_ovf = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			mdl_ovf = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Divide by d and round to nearest, ties toward plus infinity (floor of n + d/2 over d).
	function automatic longint round_div(input longint n, input longint d);
		longint s, q;
		s = n + d / 2;
		q = s / d;
		if ((s % d) != 0 && s < 0)
			q--;
		return q;
	endfunction

	function automatic longint fx_mul(input longint p, input longint q);
		return clamp32(round_div(p * q, 65536));
	endfunction

	// Derivatives of x and y.
	function automatic void rates(input longint x, input longint y, output longint fx,
			output longint fy);
		longint axxy, bx;
		axxy = fx_mul(fx_mul(fx_mul(mdl_a, x), x), y);
		bx = fx_mul(mdl_b, x);
		fx = clamp32(65536 - (bx + x) + axxy);
		fy = clamp32(bx - axxy);
	endfunction

	// The result that one item leaves in the state.
	function automatic brs_tb_pkg::conc_result_t advance_conc(input brs_tb_pkg::conc_cmd_t c);
		brs_tb_pkg::conc_result_t r;
		longint k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y, sx, sy;
		mdl_ovf = 0;
		if (c.action == brs_pkg::ACT_LOAD) begin
			mdl_x = longint'(c.load_x);
			mdl_y = longint'(c.load_y);
		end else begin
			rates(mdl_x, mdl_y, k1x, k1y);
			rates(clamp32(mdl_x + round_div(mdl_dt * k1x, 131072)),
				clamp32(mdl_y + round_div(mdl_dt * k1y, 131072)), k2x, k2y);
			rates(clamp32(mdl_x + round_div(mdl_dt * k2x, 131072)),
				clamp32(mdl_y + round_div(mdl_dt * k2y, 131072)), k3x, k3y);
			rates(clamp32(mdl_x + round_div(mdl_dt * k3x, 65536)),
				clamp32(mdl_y + round_div(mdl_dt * k3y, 65536)), k4x, k4y);
			sx = k1x + 2 * k2x + 2 * k3x + k4x;
			sy = k1y + 2 * k2y + 2 * k3y + k4y;
			mdl_x = clamp32(mdl_x + round_div(mdl_dt * sx, 393216));
			mdl_y = clamp32(mdl_y + round_div(mdl_dt * sy, 393216));
		end
		r.new_x = mdl_x[31:0];
		r.new_y = mdl_y[31:0];
		r.overflow = mdl_ovf;
		return r;
	endfunction

	// The sender works in bursts: a burst of items back to back, then a gap of random length.
	int burst_left = 0;
	int gap_left = 0;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.action <= brs_pkg::ACT_STEP;
			req.load_x <= '0;
			req.load_y <= '0;
			req_taken = 0;
		end else if (req.valid && !req_taken) begin
			// An item is offered and not yet taken: it holds as it is.
		end else if (gap_left > 0) begin
			gap_left--;
			req.valid <= 1'b0;
		end else if (pending_cmds.size() > 0) begin
			req.valid <= 1'b1;
			req.action <= pending_cmds[0].action;
			req.load_x <= pending_cmds[0].load_x;
			req.load_y <= pending_cmds[0].load_y;
			req_taken = 0;
			void'(pending_cmds.pop_front());
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 6);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			end
		end else begin
			req.valid <= 1'b0;
		end
	end

	// The receiver stalls in its own pattern: long runs of ready, then long runs of stall.
	int stall_phase = 0;

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			stall_phase = (stall_phase + 1) % 600;
			if (stall_phase < 300)
				rsp.ready <= 1'b1;
			else if (stall_phase < 450)
				rsp.ready <= ($urandom_range(0, 3) != 0);
			else
				rsp.ready <= ($urandom_range(0, 7) == 0);
		end
	end

	// The input side: an accepted item enters the model, and its result goes to the back of
	// the expected queue.
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) begin
			brs_tb_pkg::conc_cmd_t c;
			brs_tb_pkg::conc_result_t r;
			req_taken = 1;
			c.action = req.action;
			c.load_x = req.load_x;
			c.load_y = req.load_y;
			r = advance_conc(c);
			expected_results.insert(expected_results.size(), r);
			if (c.action == brs_pkg::ACT_LOAD)
				n_loads++;
			else
				n_steps++;
		end
	end

	// The output side: each result is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			brs_tb_pkg::conc_result_t e;
			n_results++;
			if (expected_results.size() == 0) begin
				$error("result with no expected result waiting");
				n_fail++;
			end else begin
				e = expected_results.pop_front();
				if (e.overflow)
					n_sat++;
				if (rsp.new_x !== e.new_x) begin
					$error("new_x: expected %0d, actual %0d", e.new_x, rsp.new_x);
					n_fail++;
				end
				if (rsp.new_y !== e.new_y) begin
					$error("new_y: expected %0d, actual %0d", e.new_y, rsp.new_y);
					n_fail++;
				end
				if (rsp.overflow !== e.overflow) begin
					$error("overflow: expected %0d, actual %0d", e.overflow, rsp.overflow);
					n_fail++;
				end
			end
		end
	end

	// The watchdog counts cycles in which nothing is accepted on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
					(stim_done && expected_results.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item accepted in %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// One register write, with the block idle.
	task automatic write_reg(input brs_pkg::reg_idx_t idx, input logic [brs_pkg::QW-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			brs_pkg::REG_COEF_A:    mdl_a = longint'(value[30:0]);
			brs_pkg::REG_COEF_B:    mdl_b = longint'(value[30:0]);
			brs_pkg::REG_STEP_SIZE: mdl_dt = longint'(value[16:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Wait until every item has been sent and every result has arrived.
	task automatic drain();
		while (pending_cmds.size() > 0 || req.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_cmd(input logic act, input logic [31:0] lx, input logic [31:0] ly);
		brs_tb_pkg::conc_cmd_t c;
		c.action = act;
		c.load_x = lx;
		c.load_y = ly;
		pending_cmds.insert(pending_cmds.size(), c);
	endtask

	// A value that is usually moderate and sometimes anywhere in the whole range.
	function automatic logic [31:0] rand_conc();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			default: return $urandom_range(0, 32'h0040_0000);
		endcase
	endfunction

	// One phase of random work: n items, each a step or, one time in ten, a load of random
	// concentrations.
	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				add_cmd(brs_pkg::ACT_LOAD, rand_conc(), rand_conc());
			else
				add_cmd(brs_pkg::ACT_STEP, $urandom, $urandom);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.action = brs_pkg::ACT_STEP;
		req.load_x = '0;
		req.load_y = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = brs_pkg::REG_COEF_A;
		cfg.data = '0;
		mdl_x = 0;
		mdl_y = 0;
		mdl_a = 65536;
		mdl_b = 655360;
		mdl_dt = 655;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items with the reset registers: a step from the reset state, loads of the
		// extremes of x and y, steps after each one, and a step that saturates.
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_LOAD, 32'h0001_0000, 32'h0003_0000);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_cmd(brs_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_LOAD, 32'h8000_0000, 32'h8000_0000);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'h0000_0001);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		drain();

		// The extremes of the registers: a zero step size, and the largest coefficients with
		// a full step of 1.0.
		write_reg(brs_pkg::REG_STEP_SIZE, 32'd0);
		add_cmd(brs_pkg::ACT_LOAD, 32'h0002_0000, 32'h0001_0000);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		drain();
		write_reg(brs_pkg::REG_COEF_A, 32'h7FFF_FFFF);
		write_reg(brs_pkg::REG_COEF_B, 32'h7FFF_FFFF);
		write_reg(brs_pkg::REG_STEP_SIZE, 32'd65536);
		add_cmd(brs_pkg::ACT_LOAD, 32'h0001_0000, 32'h0001_0000);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		drain();
		// Step size above 1.0 and zero coefficients.
		write_reg(brs_pkg::REG_COEF_A, 32'd0);
		write_reg(brs_pkg::REG_COEF_B, 32'd0);
		write_reg(brs_pkg::REG_STEP_SIZE, 32'h0001_FFFF);
		add_cmd(brs_pkg::ACT_LOAD, 32'h0000_8000, 32'hFFFF_8000);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		add_cmd(brs_pkg::ACT_STEP, '0, '0);
		drain();

		// Random phases, each with its own register settings: the reset values, random
		// values of every size, and the extremes.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					write_reg(brs_pkg::REG_COEF_A, 32'd65536);
					write_reg(brs_pkg::REG_COEF_B, 32'd655360);
					write_reg(brs_pkg::REG_STEP_SIZE, 32'd655);
				end
				1: begin
					write_reg(brs_pkg::REG_COEF_A, 32'h7FFF_FFFF);
					write_reg(brs_pkg::REG_COEF_B, 32'd0);
					write_reg(brs_pkg::REG_STEP_SIZE, 32'd65536);
				end
				2: begin
					write_reg(brs_pkg::REG_COEF_A, 32'd0);
					write_reg(brs_pkg::REG_COEF_B, 32'h7FFF_FFFF);
					write_reg(brs_pkg::REG_STEP_SIZE, 32'd0);
				end
				default: begin
					write_reg(brs_pkg::REG_COEF_A, ($urandom_range(0, 1) == 0) ? $urandom :
						$urandom_range(0, 32'h0004_0000));
					write_reg(brs_pkg::REG_COEF_B, ($urandom_range(0, 1) == 0) ? $urandom :
						$urandom_range(0, 32'h0010_0000));
					write_reg(brs_pkg::REG_STEP_SIZE, ($urandom_range(0, 1) == 0) ? $urandom :
						$urandom_range(0, 8192));
				end
			endcase
			add_cmd(brs_pkg::ACT_LOAD, rand_conc(), rand_conc());
			random_phase(105);
			drain();
		end

		stim_done = 1;
		$display("%0d items: %0d loads, %0d steps, %0d results with saturation",
			n_results, n_loads, n_steps, n_sat);
		$display("register settings covered the zero and full extremes of each register");
		if (n_fail == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
